### sv/rrqs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the round-robin quantum scheduler.
package rrqs_pkg;

   localparam int ID_W    = 4;
   localparam int BURST_W = 16;
   localparam int TIME_W  = 32;

   localparam logic [BURST_W-1:0] QUANTUM_RESET = 16'd4;

   typedef enum logic {
      OP_ARRIVE = 1'b0,
      OP_TICK   = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_ACTIVE     = 2'd1,
      STATUS_ZERO_BURST = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_POP,
      ST_FETCH,
      ST_DISPATCH,
      ST_EXEC,
      ST_REPLY
   } state_type;

   typedef struct packed {
      op_type               operation;
      logic [ID_W-1:0]      task_id;
      logic [BURST_W-1:0]   burst;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic                 running_valid;
      logic [ID_W-1:0]      running_task;
      logic                 task_done;
      logic [TIME_W-1:0]    finish_time;
      logic [TIME_W-1:0]    time_now;
   } rsp_type;

endpackage

### sv/round_robin_quantum_scheduler_top.sv
`timescale 1ns / 1ps
// Top level of the round-robin scheduler with a time quantum.
//
//  channel | ports                          | carries
//  --------+--------------------------------+--------------------------------------
//  request | req_valid, req_ready, req_data | arrival (id, burst) or one time tick
//  result  | rsp_valid, rsp_ready, rsp_data | status, task that ran, completion, time
//  csr     | csr_valid, csr_ready, csr_data | time quantum, ready whenever out of reset
//
// An arrival passes through the setup and reply states, a tick that keeps the
// running task or idles passes through setup, execute and reply, and a tick that
// dispatches a new task also passes through pop, fetch and dispatch before execute:
// the ready FIFO memory read and then the burst memory read sit one after the other in that path.
// Synchronous active-high reset clears all control state; the two memories need
// no clearing pass, since only entries already written are ever read.
// A stalled result stays in the output register while the next request is taken;
// only the reply step waits for that register to free up.
module round_robin_quantum_scheduler_top
   import rrqs_pkg::*;
#(
   parameter int MAX_TASKS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [BURST_W-1:0] csr_data
);

   localparam int IDX_W = $clog2(MAX_TASKS);
   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_TASKS - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_TASKS);

   // Advance a ring pointer, wrapping after the last entry.
   function automatic logic [IDX_W-1:0] next_ptr(input logic [IDX_W-1:0] p);
      return (p == LAST_IDX) ? '0 : p + IDX_W'(1);
   endfunction

   // sequencer
   state_type state_ff, state_in;

   // request holding register and configuration
   req_type              item_ff;
   logic [BURST_W-1:0]   quantum_ff, quantum_in;

   // scheduler control state
   logic                 busy_ff, busy_in;
   logic [ID_W-1:0]      cur_task_ff, cur_task_in;
   logic [BURST_W-1:0]   slice_ff, slice_in;
   logic [BURST_W-1:0]   cur_rem_ff, cur_rem_in;
   logic [TIME_W-1:0]    time_ff, time_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [IDX_W-1:0]     tail_ff, tail_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [MAX_TASKS-1:0] active_ff, active_in;

   // result staging and output register
   rsp_type              res_ff, res_in;
   rsp_type              rsp_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 reply_load;

   // memory ports
   logic                 fifo_we;
   logic [ID_W-1:0]      fifo_wdata;
   logic [ID_W-1:0]      fifo_rdata;
   logic                 burst_we;
   logic [IDX_W-1:0]     burst_waddr;
   logic [BURST_W-1:0]   burst_wdata;
   logic [BURST_W-1:0]   burst_rdata;

   // decode helpers
   logic [IDX_W-1:0]     item_idx;
   logic [IDX_W-1:0]     cur_idx;
   logic                 id_ok;
   logic                 requeue;
   logic                 need_pop;
   logic                 fifo_has_room;
   logic [BURST_W-1:0]   q_eff;
   logic [BURST_W-1:0]   rem_dec;
   logic [TIME_W-1:0]    time_next;

   // ready FIFO of task ids, indexed by the head and tail pointers
   rrqs_ram #(
      .DEPTH  (MAX_TASKS),
      .WIDTH  (ID_W),
      .ADDR_W (IDX_W)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (tail_ff),
      .wr_data (fifo_wdata),
      .rd_addr (head_ff),
      .rd_data (fifo_rdata)
   );

   // remaining burst per task id; read for the id just popped from the FIFO
   rrqs_ram #(
      .DEPTH  (MAX_TASKS),
      .WIDTH  (BURST_W),
      .ADDR_W (IDX_W)
   ) u_burst_ram (
      .clock   (clock),
      .wr_en   (burst_we),
      .wr_addr (burst_waddr),
      .wr_data (burst_wdata),
      .rd_addr (IDX_W'(fifo_rdata)),
      .rd_data (burst_rdata)
   );

   assign item_idx      = IDX_W'(item_ff.task_id);
   assign cur_idx       = IDX_W'(cur_task_ff);
   assign id_ok         = (32'(item_ff.task_id) < MAX_TASKS);
   // a slice that ran out with work left goes back to the tail first
   assign requeue       = busy_ff && (slice_ff == '0);
   assign need_pop      = (!busy_ff || requeue) && ((count_ff != '0) || requeue);
   assign fifo_has_room = (count_ff != FULL_CNT);
   assign q_eff         = (quantum_ff == '0) ? BURST_W'(1) : quantum_ff;
   assign rem_dec       = (cur_rem_ff == '0) ? '0 : cur_rem_ff - BURST_W'(1);
   assign time_next     = time_ff + TIME_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (item_ff.operation == OP_ARRIVE) begin
               state_in = ST_REPLY;
            end else if (need_pop) begin
               state_in = ST_POP;
            end else begin
               state_in = ST_EXEC;
            end
         end
         ST_POP:      state_in = ST_FETCH;
         ST_FETCH:    state_in = ST_DISPATCH;
         ST_DISPATCH: state_in = ST_EXEC;
         ST_EXEC:     state_in = ST_REPLY;
         ST_REPLY: begin
            if (reply_load) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs; hold off transfers while in reset
   always_comb begin
      req_ready  = 1'b0;
      reply_load = 1'b0;
      case (state_ff)
         ST_IDLE:  req_ready  = !reset;
         ST_REPLY: reply_load = !rsp_valid_ff || rsp_ready;
         default: begin
            req_ready  = 1'b0;
            reply_load = 1'b0;
         end
      endcase
   end

   // scheduler datapath
   always_comb begin
      busy_in     = busy_ff;
      cur_task_in = cur_task_ff;
      slice_in    = slice_ff;
      cur_rem_in  = cur_rem_ff;
      time_in     = time_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      active_in   = active_ff;
      res_in      = res_ff;
      fifo_we     = 1'b0;
      fifo_wdata  = item_ff.task_id;
      burst_we    = 1'b0;
      burst_waddr = item_idx;
      burst_wdata = item_ff.burst;

      case (state_ff)
         ST_SETUP: begin
            if (item_ff.operation == OP_ARRIVE) begin
               res_in               = '0;
               res_in.time_now      = time_ff;
               if (!id_ok || active_ff[item_idx]) begin
                  // active id check wins over the zero burst check
                  res_in.status = STATUS_ACTIVE;
               end else if (item_ff.burst == '0) begin
                  res_in.status = STATUS_ZERO_BURST;
               end else begin
                  res_in.status       = STATUS_OK;
                  active_in[item_idx] = 1'b1;
                  burst_we            = 1'b1;
                  if (fifo_has_room) begin
                     fifo_we  = 1'b1;
                     tail_in  = next_ptr(tail_ff);
                     count_in = count_ff + CNT_W'(1);
                  end
               end
            end else if (requeue) begin
               // write back the remaining burst and put the task behind arrivals
               busy_in     = 1'b0;
               burst_we    = 1'b1;
               burst_waddr = cur_idx;
               burst_wdata = cur_rem_ff;
               fifo_wdata  = cur_task_ff;
               if (fifo_has_room) begin
                  fifo_we  = 1'b1;
                  tail_in  = next_ptr(tail_ff);
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         ST_POP: begin
            head_in  = next_ptr(head_ff);
            count_in = count_ff - CNT_W'(1);
         end
         ST_FETCH: begin
            cur_task_in = fifo_rdata;
         end
         ST_DISPATCH: begin
            cur_rem_in = burst_rdata;
            slice_in   = (burst_rdata < q_eff) ? burst_rdata : q_eff;
            busy_in    = 1'b1;
         end
         ST_EXEC: begin
            res_in          = '0;
            res_in.status   = STATUS_OK;
            res_in.time_now = time_next;
            time_in         = time_next;
            if (busy_ff) begin
               res_in.running_valid = 1'b1;
               res_in.running_task  = cur_task_ff;
               cur_rem_in           = rem_dec;
               slice_in             = (slice_ff == '0) ? '0 : slice_ff - BURST_W'(1);
               if (rem_dec == '0) begin
                  res_in.task_done   = 1'b1;
                  res_in.finish_time = time_next;
                  active_in[cur_idx] = 1'b0;
                  busy_in            = 1'b0;
                  slice_in           = '0;
               end
            end
         end
         default: begin
            res_in = res_ff;
         end
      endcase
   end

   // configuration write: taken whenever out of reset; the sender writes only while idle
   assign csr_ready  = !reset;
   assign quantum_in = (csr_valid && csr_ready) ? csr_data : quantum_ff;

   // hold the result until taken; a new load replaces a taken one
   assign rsp_valid_in = reply_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         quantum_ff   <= QUANTUM_RESET;
         busy_ff      <= 1'b0;
         cur_task_ff  <= '0;
         slice_ff     <= '0;
         cur_rem_ff   <= '0;
         time_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         quantum_ff   <= quantum_in;
         busy_ff      <= busy_in;
         cur_task_ff  <= cur_task_in;
         slice_ff     <= slice_in;
         cur_rem_ff   <= cur_rem_in;
         time_ff      <= time_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
      res_ff <= res_in;
      if (reply_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // the ready FIFO never holds more ids than it has entries
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("ready FIFO count beyond its depth");

   // a task that holds the CPU is still marked active
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> active_ff[cur_idx])
      else $error("running task is not active");

   // the slice never outlasts the work left for the task
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (slice_ff <= cur_rem_ff))
      else $error("slice longer than remaining burst");

   // a dispatched task always comes back from memory with work left
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DISPATCH) |-> (burst_rdata != '0))
      else $error("dispatched task has no remaining burst");
`endif

endmodule

### sv/rrqs_ram.sv
`timescale 1ns / 1ps
// Single-port-write, registered-read synchronous RAM for the scheduler state.
module rrqs_ram #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 4,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data is registered and lands in the cycle after the address
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
